// ----- hw/rtl/nlpp_pkg.sv -----
// Package for the note link pulse port: phase codes, event kinds,
// register indexes, reset values and the result record type.
// No dependencies; used by note_link_pulse_port_unit.
package nlpp_pkg;

  // Event kinds carried by an input transaction.
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_TRIGGER = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ON_TIME    = 2'd0;
  localparam logic [1:0] CFG_GAP_TICKS  = 2'd1;
  localparam logic [1:0] CFG_HOLD_LIMIT = 2'd2;

  // Phase codes of the writer. Other codes hold like wait but count as playing.
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_ON    = 3'd1;
  localparam logic [2:0] PH_OFF   = 3'd2;
  localparam logic [2:0] PH_REST  = 3'd3;
  localparam logic [2:0] PH_WAIT  = 3'd6;

  // Highest note value that is played; larger values are rests.
  localparam logic [5:0] NOTE_MAX = 6'd48;

  // Register reset values.
  localparam logic [7:0]  ON_TIME_RST    = 8'd2;
  localparam logic [7:0]  GAP_TICKS_RST  = 8'd16;
  localparam logic [15:0] HOLD_LIMIT_RST = 16'd100;

  // Saturation limits of the timers.
  localparam logic [7:0]  PULSE_MAX = 8'hFF;
  localparam logic [23:0] PLAY_MAX  = 24'hFF_FFFF;
  localparam logic [15:0] HOLD_MAX  = 16'hFFFF;

  // One result record.
  typedef struct packed {
    logic       drive_enable;
    logic       drive_trigger;
    logic [5:0] drive_value;
    logic [5:0] current_value;
    logic       playing;
    logic       reading;
  } result_t;

endpackage

// ----- hw/rtl/note_link_pulse_port_unit.sv -----
// Note link pulse port: writer pulse sequencer, reader capture and the
// output register with a skid stage.
// Depends on nlpp_pkg.
//
// Usage: each input transaction is one event: a tick, a write command
// (note and duration) or a trigger edge with the sensed note. Every input
// transaction produces exactly one result transaction that shows the port
// state after the event. Configuration writes (pulse on length, gap length
// between pulses, hold limit of the reading flag) are taken through cfg_we,
// cfg_index and cfg_wdata; the user must make them while no event is in
// flight; the block does not enforce this. An accepted event's result is
// registered in the output register, or in the skid while the receiver
// stalls. Throughput is one event per cycle while in_stall is low.
// Reset (rst_n low, synchronous) returns the port to the idle wait phase,
// clears all timers and flags and empties the result register and skid.
// When the receiver stalls, the current result holds and one more result
// is parked in the skid stage; in_stall rises only while the skid is full.
module note_link_pulse_port_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [5:0]  in_write_note,
  input  logic [23:0] in_duration,
  input  logic [5:0]  in_sensed_note,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_drive_enable,
  output logic        out_drive_trigger,
  output logic [5:0]  out_drive_value,
  output logic [5:0]  out_current_value,
  output logic        out_playing,
  output logic        out_reading,
  // Configuration port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers.
  logic [7:0]  on_time_r;
  logic [7:0]  gap_ticks_r;
  logic [15:0] hold_limit_r;

  // Port state and its next value.
  logic [2:0]  phase_r,           phase_nxt;
  logic [7:0]  pulse_timer_r,     pulse_timer_nxt;
  logic [23:0] play_timer_r,      play_timer_nxt;
  logic [23:0] play_length_r,     play_length_nxt;
  logic [5:0]  send_value_r,      send_value_nxt;
  logic        driving_r,         driving_nxt;
  logic [5:0]  shown_value_r,     shown_value_nxt;
  logic        capture_pending_r, capture_pending_nxt;
  logic [5:0]  captured_value_r,  captured_value_nxt;
  logic        held_flag_r,       held_flag_nxt;
  logic [15:0] hold_timer_r,      hold_timer_nxt;

  // Output register and skid stage.
  nlpp_pkg::result_t out_res_r, skid_res_r, res_nxt;
  logic              out_valid_r, skid_valid_r;

  logic in_acc;
  logic out_acc;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_acc  = out_valid_r && !out_stall;

  // Configuration writes; index three is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_time_r    <= nlpp_pkg::ON_TIME_RST;
      gap_ticks_r  <= nlpp_pkg::GAP_TICKS_RST;
      hold_limit_r <= nlpp_pkg::HOLD_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        nlpp_pkg::CFG_ON_TIME:    on_time_r    <= cfg_wdata[7:0];
        nlpp_pkg::CFG_GAP_TICKS:  gap_ticks_r  <= cfg_wdata[7:0];
        nlpp_pkg::CFG_HOLD_LIMIT: hold_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Event processing: next state for one event.
  always_comb begin
    phase_nxt           = phase_r;
    pulse_timer_nxt     = pulse_timer_r;
    play_timer_nxt      = play_timer_r;
    play_length_nxt     = play_length_r;
    send_value_nxt      = send_value_r;
    driving_nxt         = driving_r;
    shown_value_nxt     = shown_value_r;
    capture_pending_nxt = capture_pending_r;
    captured_value_nxt  = captured_value_r;
    held_flag_nxt       = held_flag_r;
    hold_timer_nxt      = hold_timer_r;

    case (in_kind)
      nlpp_pkg::KIND_TICK: begin
        // Timers advance first and saturate.
        if (pulse_timer_r != nlpp_pkg::PULSE_MAX) pulse_timer_nxt = pulse_timer_r + 8'd1;
        if (play_timer_r != nlpp_pkg::PLAY_MAX)   play_timer_nxt  = play_timer_r + 24'd1;
        if (hold_timer_r != nlpp_pkg::HOLD_MAX)   hold_timer_nxt  = hold_timer_r + 16'd1;

        // Adopt a pending capture, or else let the reading flag expire.
        if (capture_pending_r) begin
          held_flag_nxt       = 1'b1;
          hold_timer_nxt      = '0;
          shown_value_nxt     = captured_value_r;
          capture_pending_nxt = 1'b0;
        end else if (held_flag_r && (hold_timer_nxt > hold_limit_r)) begin
          held_flag_nxt = 1'b0;
        end

        // Writer phase sequencer.
        case (phase_r)
          nlpp_pkg::PH_START: begin
            driving_nxt     = 1'b1;
            pulse_timer_nxt = '0;
            phase_nxt       = nlpp_pkg::PH_ON;
          end
          nlpp_pkg::PH_ON: begin
            if (pulse_timer_nxt > on_time_r) begin
              driving_nxt     = 1'b0;
              pulse_timer_nxt = '0;
              phase_nxt       = nlpp_pkg::PH_OFF;
            end
          end
          nlpp_pkg::PH_OFF: begin
            if (pulse_timer_nxt > gap_ticks_r) begin
              phase_nxt = (play_timer_nxt < play_length_r) ? nlpp_pkg::PH_START
                                                           : nlpp_pkg::PH_WAIT;
            end
          end
          nlpp_pkg::PH_REST: begin
            if (play_timer_nxt >= play_length_r) phase_nxt = nlpp_pkg::PH_WAIT;
          end
          default: ;
        endcase
      end
      nlpp_pkg::KIND_WRITE: begin
        // A playable note starts pulsing; anything larger is a rest.
        if (in_write_note <= nlpp_pkg::NOTE_MAX) begin
          phase_nxt       = nlpp_pkg::PH_START;
          send_value_nxt  = in_write_note;
          shown_value_nxt = in_write_note;
        end else begin
          phase_nxt = nlpp_pkg::PH_REST;
        end
        play_length_nxt = in_duration;
        play_timer_nxt  = '0;
      end
      nlpp_pkg::KIND_TRIGGER: begin
        // Capture only while the pins are released and nothing is pending.
        if (!(driving_r || capture_pending_r)) begin
          capture_pending_nxt = 1'b1;
          captured_value_nxt  = in_sensed_note;
        end
      end
      default: ;
    endcase

    // Result record built from the state after the event.
    res_nxt.drive_enable  = driving_nxt;
    res_nxt.drive_trigger = driving_nxt;
    res_nxt.drive_value   = driving_nxt ? send_value_nxt : 6'd0;
    res_nxt.current_value = shown_value_nxt;
    res_nxt.playing       = (phase_nxt != nlpp_pkg::PH_WAIT);
    res_nxt.reading       = held_flag_nxt;
  end

  // State registers, updated once per accepted input transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= nlpp_pkg::PH_WAIT;
      pulse_timer_r     <= '0;
      play_timer_r      <= '0;
      play_length_r     <= '0;
      send_value_r      <= '0;
      driving_r         <= 1'b0;
      shown_value_r     <= '0;
      capture_pending_r <= 1'b0;
      captured_value_r  <= '1;
      held_flag_r       <= 1'b0;
      hold_timer_r      <= '0;
    end else if (in_acc) begin
      phase_r           <= phase_nxt;
      pulse_timer_r     <= pulse_timer_nxt;
      play_timer_r      <= play_timer_nxt;
      play_length_r     <= play_length_nxt;
      send_value_r      <= send_value_nxt;
      driving_r         <= driving_nxt;
      shown_value_r     <= shown_value_nxt;
      capture_pending_r <= capture_pending_nxt;
      captured_value_r  <= captured_value_nxt;
      held_flag_r       <= held_flag_nxt;
      hold_timer_r      <= hold_timer_nxt;
    end
  end

  // Output register with skid: a new result goes to the output register
  // when it is free or being taken, otherwise it parks in the skid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_acc) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_acc) begin
      if (skid_valid_r) begin
        out_res_r <= skid_res_r;
      end else if (in_acc) begin
        out_res_r <= res_nxt;
      end
    end else if (in_acc) begin
      skid_res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_enable  = out_res_r.drive_enable;
  assign out_drive_trigger = out_res_r.drive_trigger;
  assign out_drive_value   = out_res_r.drive_value;
  assign out_current_value = out_res_r.current_value;
  assign out_playing       = out_res_r.playing;
  assign out_reading       = out_res_r.reading;

endmodule

// ----- dv/nlpp_checker.sv -----
// Checker for the note link pulse port: watches the input, result and
// configuration ports, predicts each result and compares it field by field.
// Depends on nlpp_pkg.
module nlpp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [5:0]  in_write_note,
  input  logic [23:0] in_duration,
  input  logic [5:0]  in_sensed_note,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_drive_enable,
  input  logic        out_drive_trigger,
  input  logic [5:0]  out_drive_value,
  input  logic [5:0]  out_current_value,
  input  logic        out_playing,
  input  logic        out_reading,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  // Shadow copy of the configuration registers.
  logic [7:0]  on_len;
  logic [7:0]  off_len;
  logic [15:0] release_len;

  // Shadow copy of the port state.
  logic [2:0]  writer_phase;
  logic [7:0]  pulse_ticks;
  logic [23:0] play_ticks;
  logic [23:0] play_len;
  logic [5:0]  send_note;
  logic        drive_on;
  logic [5:0]  shown_note;
  logic        capture_wait;
  logic [5:0]  captured_note;
  logic        hold_on;
  logic [15:0] hold_ticks;

  // Port views still owed by the block, oldest first.
  nlpp_pkg::result_t port_views[$];

  // Advance the shadow state by one event.
  task automatic step_port(input logic [1:0] kind, input logic [5:0] note,
                           input logic [23:0] dur, input logic [5:0] sensed);
    case (kind)
      nlpp_pkg::KIND_TICK: begin
        // Timers advance first and stop at their maximum.
        if (pulse_ticks != nlpp_pkg::PULSE_MAX) pulse_ticks++;
        if (play_ticks != nlpp_pkg::PLAY_MAX) play_ticks++;
        if (hold_ticks != nlpp_pkg::HOLD_MAX) hold_ticks++;
        // A pending capture is adopted; otherwise the reading flag may drop.
        if (capture_wait) begin
          hold_on = 1'b1;
          hold_ticks = '0;
          shown_note = captured_note;
          capture_wait = 1'b0;
        end else if (hold_on && hold_ticks > release_len) begin
          hold_on = 1'b0;
        end
        // The writer sequence steps last.
        case (writer_phase)
          nlpp_pkg::PH_START: begin
            drive_on = 1'b1;
            pulse_ticks = '0;
            writer_phase = nlpp_pkg::PH_ON;
          end
          nlpp_pkg::PH_ON: if (pulse_ticks > on_len) begin
            drive_on = 1'b0;
            pulse_ticks = '0;
            writer_phase = nlpp_pkg::PH_OFF;
          end
          nlpp_pkg::PH_OFF: if (pulse_ticks > off_len) begin
            writer_phase = (play_ticks < play_len) ? nlpp_pkg::PH_START
                                                   : nlpp_pkg::PH_WAIT;
          end
          nlpp_pkg::PH_REST: if (play_ticks >= play_len) begin
            writer_phase = nlpp_pkg::PH_WAIT;
          end
          default: ;
        endcase
      end
      nlpp_pkg::KIND_WRITE: begin
        // Playable notes start a pulse train; larger values play a rest.
        if (note <= nlpp_pkg::NOTE_MAX) begin
          writer_phase = nlpp_pkg::PH_START;
          send_note = note;
          shown_note = note;
        end else begin
          writer_phase = nlpp_pkg::PH_REST;
        end
        play_len = dur;
        play_ticks = '0;
      end
      nlpp_pkg::KIND_TRIGGER: if (!(drive_on || capture_wait)) begin
        capture_wait = 1'b1;
        captured_note = sensed;
      end
      default: ;
    endcase
  endtask

  // What the result channel should show for the current shadow state.
  function automatic nlpp_pkg::result_t port_view();
    nlpp_pkg::result_t r;
    r.drive_enable  = drive_on;
    r.drive_trigger = drive_on;
    r.drive_value   = drive_on ? send_note : '0;
    r.current_value = shown_note;
    r.playing       = (writer_phase != nlpp_pkg::PH_WAIT);
    r.reading       = hold_on;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Everything is sampled at the rising edge, before the edge's updates land.
  always @(posedge clk) begin : watch
    nlpp_pkg::result_t got;
    nlpp_pkg::result_t want;
    if (!rst_n) begin
      on_len        = nlpp_pkg::ON_TIME_RST;
      off_len       = nlpp_pkg::GAP_TICKS_RST;
      release_len   = nlpp_pkg::HOLD_LIMIT_RST;
      writer_phase  = nlpp_pkg::PH_WAIT;
      pulse_ticks   = '0;
      play_ticks    = '0;
      play_len      = '0;
      send_note     = '0;
      drive_on      = 1'b0;
      shown_note    = '0;
      capture_wait  = 1'b0;
      captured_note = '1;
      hold_on       = 1'b0;
      hold_ticks    = '0;
      port_views.delete();
    end else begin
      // Register writes take effect at the edge that carries them.
      if (cfg_we) begin
        case (cfg_index)
          nlpp_pkg::CFG_ON_TIME:    on_len = cfg_wdata[7:0];
          nlpp_pkg::CFG_GAP_TICKS:  off_len = cfg_wdata[7:0];
          nlpp_pkg::CFG_HOLD_LIMIT: release_len = cfg_wdata;
          default: ;
        endcase
      end
      // A result transaction is matched against the oldest prediction.
      if (out_valid && !out_stall) begin
        got = {out_drive_enable, out_drive_trigger, out_drive_value,
               out_current_value, out_playing, out_reading};
        if (port_views.size() == 0) begin
          $error("result transaction with no prediction waiting");
          fail_count++;
        end else begin
          want = port_views.pop_front();
          check_field("drive_enable", want.drive_enable, got.drive_enable);
          check_field("drive_trigger", want.drive_trigger, got.drive_trigger);
          check_field("drive_value", want.drive_value, got.drive_value);
          check_field("current_value", want.current_value, got.current_value);
          check_field("playing", want.playing, got.playing);
          check_field("reading", want.reading, got.reading);
        end
      end
      // Every input transaction yields exactly one result.
      if (in_valid && !in_stall) begin
        step_port(in_kind, in_write_note, in_duration, in_sensed_note);
        port_views.push_back(port_view());
      end
    end
    pending = port_views.size();
  end

endmodule

// ----- dv/tb_note_link_pulse_port_unit.sv -----
// Top of the note link pulse port testbench: clock, reset, stimulus and
// receiver stalls, with nlpp_checker doing prediction and comparison.
// Depends on nlpp_pkg, nlpp_checker and note_link_pulse_port_unit.
module tb_note_link_pulse_port_unit;

  // Kind code the block has no use for; it must only report its state.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [5:0]  in_write_note;
  logic [23:0] in_duration;
  logic [5:0]  in_sensed_note;
  logic        out_valid;
  logic        out_stall;
  logic        out_drive_enable;
  logic        out_drive_trigger;
  logic [5:0]  out_drive_value;
  logic [5:0]  out_current_value;
  logic        out_playing;
  logic        out_reading;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  int fail_count;
  int pending;

  // Idling rates in percent per cycle, and the long hold-off request.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;

  always #4 clk = ~clk;

  note_link_pulse_port_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_write_note    (in_write_note),
    .in_duration      (in_duration),
    .in_sensed_note   (in_sensed_note),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drive_enable (out_drive_enable),
    .out_drive_trigger(out_drive_trigger),
    .out_drive_value  (out_drive_value),
    .out_current_value(out_current_value),
    .out_playing      (out_playing),
    .out_reading      (out_reading),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  nlpp_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_write_note    (in_write_note),
    .in_duration      (in_duration),
    .in_sensed_note   (in_sensed_note),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drive_enable (out_drive_enable),
    .out_drive_trigger(out_drive_trigger),
    .out_drive_value  (out_drive_value),
    .out_current_value(out_current_value),
    .out_playing      (out_playing),
    .out_reading      (out_reading),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Offer one event and hold it until the block takes it, then maybe idle.
  // The stall is sampled on the falling edge, where it is settled.
  task automatic send_event(input logic [1:0] kind, input logic [5:0] note,
                            input logic [23:0] dur, input logic [5:0] sensed);
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_write_note  <= note;
    in_duration    <= dur;
    in_sensed_note <= sensed;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Write all three registers on consecutive edges while the port is idle.
  task automatic write_regs(input logic [15:0] on_val, input logic [15:0] off_val,
                            input logic [15:0] rel_val);
    cfg_we    <= 1'b1;
    cfg_index <= nlpp_pkg::CFG_ON_TIME;
    cfg_wdata <= on_val;
    @(posedge clk);
    cfg_index <= nlpp_pkg::CFG_GAP_TICKS;
    cfg_wdata <= off_val;
    @(posedge clk);
    cfg_index <= nlpp_pkg::CFG_HOLD_LIMIT;
    cfg_wdata <= rel_val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Stimulus: reset, directed events, then four random phases.
  initial begin : stimulus
    logic [1:0]  ev_kind;
    logic [5:0]  ev_note;
    logic [23:0] ev_dur;
    int          roll;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_kind        <= nlpp_pkg::KIND_TICK;
    in_write_note  <= '0;
    in_duration    <= '0;
    in_sensed_note <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= nlpp_pkg::CFG_ON_TIME;
    cfg_wdata      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Capture when idle, a second trigger while one is pending, then adoption.
    send_event(nlpp_pkg::KIND_TRIGGER, 6'd0, 24'd0, 6'h2A);
    send_event(nlpp_pkg::KIND_TRIGGER, 6'd0, 24'd0, 6'h15);
    send_event(nlpp_pkg::KIND_TICK, 6'd0, 24'd0, 6'd0);
    send_event(KIND_UNUSED, 6'h3F, 24'hFF_FFFF, 6'h3F);
    // Highest playable note; a trigger while driving is ignored.
    send_event(nlpp_pkg::KIND_WRITE, nlpp_pkg::NOTE_MAX, 24'd3, 6'd0);
    send_event(nlpp_pkg::KIND_TICK, 6'd0, 24'd0, 6'd0);
    send_event(nlpp_pkg::KIND_TRIGGER, 6'd0, 24'd0, 6'h3F);
    // A rest written mid pulse keeps the pins driven.
    send_event(nlpp_pkg::KIND_WRITE, 6'h3F, 24'hFF_FFFF, 6'd0);
    repeat (4) send_event(nlpp_pkg::KIND_TICK, 6'd0, 24'd0, 6'd0);
    // Lowest note with zero duration, then a rest just above the note range.
    send_event(nlpp_pkg::KIND_WRITE, 6'd0, 24'd0, 6'd0);
    repeat (5) send_event(nlpp_pkg::KIND_TICK, 6'd0, 24'd0, 6'd0);
    send_event(nlpp_pkg::KIND_WRITE, nlpp_pkg::NOTE_MAX + 6'd1, 24'd0, 6'd0);
    send_event(nlpp_pkg::KIND_TICK, 6'd0, 24'd0, 6'd0);
    send_event(nlpp_pkg::KIND_TRIGGER, 6'd0, 24'd0, 6'd0);
    send_event(nlpp_pkg::KIND_TICK, 6'd0, 24'd0, 6'd0);

    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: begin
          write_regs(16'd0, 16'd0, 16'd0);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = 1'b1;
        end
        1: begin
          write_regs(16'(nlpp_pkg::PULSE_MAX), 16'(nlpp_pkg::PULSE_MAX),
                     nlpp_pkg::HOLD_MAX);
          send_idle_pct  = 65;
          recv_stall_pct = 0;
        end
        2: begin
          write_regs(16'($urandom_range(0, 4)), 16'($urandom_range(0, 12)),
                     16'($urandom_range(0, 150)));
          send_idle_pct  = 0;
          recv_stall_pct = 65;
        end
        default: begin
          write_regs(16'($urandom), 16'($urandom), 16'($urandom));
          send_idle_pct  = 27;
          recv_stall_pct = 27;
        end
      endcase
      // Mostly ticks so that pulses and holds run their course.
      for (int i = 0; i < 200; i++) begin
        roll = $urandom_range(99);
        if (roll < 60) ev_kind = nlpp_pkg::KIND_TICK;
        else if (roll < 78) ev_kind = nlpp_pkg::KIND_WRITE;
        else if (roll < 95) ev_kind = nlpp_pkg::KIND_TRIGGER;
        else ev_kind = KIND_UNUSED;
        ev_note = ($urandom_range(99) < 80) ? 6'($urandom_range(0, 48)) : 6'($urandom);
        ev_dur  = ($urandom_range(99) < 85) ? 24'($urandom_range(0, 40)) : 24'($urandom);
        send_event(ev_kind, ev_note, ev_dur, 6'($urandom));
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_note_link_pulse_port_unit passed");
    end else begin
      $display("tb_note_link_pulse_port_unit failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #3200000;
    $display("tb_note_link_pulse_port_unit failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/nlpp_pkg.sv
hw/rtl/note_link_pulse_port_unit.sv
dv/nlpp_checker.sv
dv/tb_note_link_pulse_port_unit.sv
